// ===== design/gfv_pkg.sv =====
`default_nettype none

package gfv_pkg;

    // Table geometry
    localparam int MAX_GROUPS  = 256;
    localparam int MAX_COLUMNS = 16;
    localparam int SLOT_W      = $clog2(MAX_GROUPS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int IDX_W       = SLOT_W + COL_W;
    localparam int TABLE_DEPTH = MAX_GROUPS * MAX_COLUMNS;
    localparam int CNT_W       = $clog2(MAX_GROUPS + 1);

    // Field widths
    localparam int OP_W    = 2;
    localparam int GRP_W   = 9;
    localparam int VAL_W   = 64;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Stream packing
    localparam int IN_BITS   = GRP_W + COL_W + VAL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = VAL_W + 3;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Missing patterns
    localparam logic [VAL_W-1:0] REAL_MISSING = 64'h7FF0_0000_0000_07A2;
    localparam logic [VAL_W-1:0] INT_MISSING  = 64'h0000_0000_8000_0000;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_OFFER = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_MISSING = 2'd0,
        CFG_GROUP_COUNT  = 2'd1,
        CFG_VALUE_KIND   = 2'd2,
        CFG_NONE         = 2'd3
    } t_cfg_idx;

    // Per-column fill counter control
    typedef struct packed {
        logic             clr;
        logic             inc;
        logic [COL_W-1:0] col;
    } t_cnt_ctrl;

endpackage

`default_nettype wire

// ===== design/gfv_ram.sv =====
`default_nettype none

module gfv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gfv_col_counts.sv =====
`default_nettype none

module gfv_col_counts
    import gfv_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cnt_ctrl        i_ctrl,
    input  wire logic [CNT_W-1:0] i_groups,
    output logic                  o_complete
);

    logic [CNT_W-1:0] r_cnt [MAX_COLUMNS];
    logic [CNT_W-1:0] w_cnt_next;

    // Count of the addressed column including this transaction's fill
    assign w_cnt_next = r_cnt[i_ctrl.col] + CNT_W'(i_ctrl.inc);
    assign o_complete = !i_ctrl.clr && (w_cnt_next >= i_groups);

    // Clear all counts at once, or bump one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            for (int i = 0; i < MAX_COLUMNS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_ctrl.inc) begin
            r_cnt[i_ctrl.col] <= w_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/grouped_first_value_table_core.sv =====
// Keeps the first value seen for each (group, column) entry of a 256 x 16 table and
// returns one result per transaction: the entry's value (or the missing pattern of the
// current kind when empty, or zero for a group out of range), its filled flag, whether
// this element was taken, and whether every group in use of that column is filled. Each
// transaction has two steps: reading the entry from the table memories, then deciding,
// writing back and loading the output register; the output register lets the next
// transaction be accepted while a result waits. After reset and after every clear
// transaction the block sweeps the 4096-entry fill-mark memory, one entry per cycle, and
// accepts no transaction during the sweep; configuration writes are taken at any time.
`default_nettype none

module grouped_first_value_table_core
    import gfv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,  // group[8:0], column[12:9], value[76:13]
    input  wire logic [OP_W-1:0]       i_s_tuser,  // op[1:0]
    // Result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [OUT_DATA_W-1:0] o_m_tdata,  // entry_value[63:0], entry_filled[64],
                                                   // taken[65], column_complete[66]
    // Configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_READ  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_sweep_cnt;

    logic              r_skip;
    logic [CFG_W-1:0]  r_group_count;
    logic              r_kind;

    t_op               r_op;
    logic [COL_W-1:0]  r_col;
    logic [IDX_W-1:0]  r_idx;
    logic              r_addr_ok;
    logic [VAL_W-1:0]  r_val;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_filled;
    logic              r_out_taken;
    logic              r_out_complete;

    logic [GRP_W-1:0]  w_in_grp;
    logic [COL_W-1:0]  w_in_col;
    logic [VAL_W-1:0]  w_in_val;
    logic [GRP_W-1:0]  w_grp_m1;
    logic [CNT_W-1:0]  w_groups;
    logic              w_in_addr_ok;
    logic [SLOT_W-1:0] w_in_slot;
    logic              w_accept;
    logic              w_load;

    logic [0:0]        w_mark_rd;
    logic [VAL_W-1:0]  w_val_rd;
    logic              w_mark_we;
    logic [IDX_W-1:0]  w_mark_waddr;
    logic [0:0]        w_mark_wdata;

    logic              w_mark;
    logic              w_missing;
    logic              w_take;
    logic [VAL_W-1:0]  w_stored;
    logic [VAL_W-1:0]  w_missing_pat;
    logic              w_complete;
    t_cnt_ctrl         w_cnt_ctrl;

    // Unpack the input transaction
    assign w_in_grp = i_s_tdata[GRP_W-1:0];
    assign w_in_col = i_s_tdata[GRP_W +: COL_W];
    assign w_in_val = i_s_tdata[GRP_W+COL_W +: VAL_W];

    // Groups in use: one when ungrouped, capped at the table size
    always_comb begin
        if (r_group_count == '0) begin
            w_groups = CNT_W'(1);
        end else if (r_group_count > CFG_W'(MAX_GROUPS)) begin
            w_groups = CNT_W'(MAX_GROUPS);
        end else begin
            w_groups = CNT_W'(r_group_count);
        end
    end

    // Map group to slot; ungrouped uses the group-one slot
    assign w_grp_m1     = w_in_grp - GRP_W'(1);
    assign w_in_addr_ok = (r_group_count == '0) ||
                          ((w_in_grp != '0) && (CNT_W'(w_in_grp) <= w_groups));
    assign w_in_slot    = (r_group_count == '0) ? '0 : w_grp_m1[SLOT_W-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_READ) && (!r_out_valid || i_m_tready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip        <= 1'b1;
            r_group_count <= '0;
            r_kind        <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SKIP_MISSING: r_skip        <= i_cfg_wdata[0];
                CFG_GROUP_COUNT:  r_group_count <= i_cfg_wdata;
                CFG_VALUE_KIND:   r_kind        <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= t_op'(i_s_tuser);
            r_col     <= w_in_col;
            r_idx     <= {w_in_col, w_in_slot};
            r_addr_ok <= w_in_addr_ok;
            r_val     <= w_in_val;
        end
    end

    // Table memories
    assign w_mark_we    = (r_state == S_SWEEP) || w_take;
    assign w_mark_waddr = (r_state == S_SWEEP) ? r_sweep_cnt : r_idx;
    assign w_mark_wdata = (r_state == S_SWEEP) ? 1'b0 : 1'b1;

    gfv_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mark_we),
        .i_wr_addr (w_mark_waddr),
        .i_wr_data (w_mark_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr ({w_in_col, w_in_slot}),
        .o_rd_data (w_mark_rd)
    );

    gfv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_take),
        .i_wr_addr (r_idx),
        .i_wr_data (w_stored),
        .i_rd_en   (w_accept),
        .i_rd_addr ({w_in_col, w_in_slot}),
        .o_rd_data (w_val_rd)
    );

    // Decide whether the element becomes the entry's first value
    always_comb begin
        if (r_kind) begin
            w_missing = (r_val[31:0] == INT_MISSING[31:0]);
            w_stored  = {32'b0, r_val[31:0]};
            w_missing_pat = INT_MISSING;
        end else begin
            w_missing = (r_val[62:52] == 11'h7FF) && (r_val[51:0] != '0);
            w_stored  = r_val;
            w_missing_pat = REAL_MISSING;
        end
    end

    assign w_mark = w_mark_rd[0] && (r_op != OP_CLEAR);
    assign w_take = w_load && r_addr_ok && (r_op == OP_OFFER) && !w_mark_rd[0] &&
                    !(r_skip && w_missing);

    // Per-column fill counts
    assign w_cnt_ctrl.clr = w_load && (r_op == OP_CLEAR);
    assign w_cnt_ctrl.inc = w_take;
    assign w_cnt_ctrl.col = r_col;

    gfv_col_counts u_col_counts (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_cnt_ctrl),
        .i_groups   (w_groups),
        .o_complete (w_complete)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_complete <= w_complete;
            if (!r_addr_ok) begin
                r_out_value  <= '0;
                r_out_filled <= 1'b0;
                r_out_taken  <= 1'b0;
            end else begin
                r_out_value  <= w_take ? w_stored : (w_mark ? w_val_rd : w_missing_pat);
                r_out_filled <= w_take || w_mark;
                r_out_taken  <= w_take;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), r_out_complete, r_out_taken,
                         r_out_filled, r_out_value};

    // Sequencer: sweep, wait for a transaction, read-modify-write
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (r_sweep_cnt == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_load) begin
                    n_state = (r_op == OP_CLEAR) ? S_SWEEP : S_IDLE;
                end
            end
            default: n_state = S_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_sweep_cnt <= r_sweep_cnt + IDX_W'(1);
            end else begin
                r_sweep_cnt <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_s_tready)
        else $error("input accepted during mark sweep");

    a_sweep_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_sweep_cnt == IDX_W'(TABLE_DEPTH - 1)) |=> (r_state == S_IDLE))
        else $error("mark sweep did not finish after the last entry");

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == OP_CLEAR) |=> (r_state == S_SWEEP && !r_out_filled))
        else $error("clear transaction did not start a sweep");

    a_taken_is_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_taken) |-> (r_out_filled && r_out_complete == $past(w_complete)
            || !$past(w_load)) )
        else $error("taken result not reported as filled");
`endif

endmodule

`default_nettype wire
